[rtl/huffman_tree_walk_decoder_defines.svh]
// Assertion macros shared by the checker of the Huffman tree-walk decoder.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH

// Clocked property, disabled while reset is high.
`define HTWD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define HTWD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   `HTWD_ASSERT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

[rtl/htwd_pkg.sv]
// Shared types and constants of the Huffman tree-walk decoder.
// Depends on nothing; used by the decoder top level and its checker.
`timescale 1ns / 1ps

package htwd_pkg;

   localparam int NODE_AW   = 9;
   localparam int NODE_SLOTS = 512;
   localparam int BYTE_BITS = 8;

   // Slot that loads never write; walking to it reads an all-zero node.
   localparam logic [NODE_AW-1:0] NULL_SLOT = 9'h1FF;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic [NODE_AW-1:0] left_child;
      logic [NODE_AW-1:0] right_child;
      logic               is_leaf;
      logic [7:0]         sym;
   } node_type;

   localparam int NODE_W = $bits(node_type);

endpackage

[rtl/htwd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module htwd_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/huffman_tree_walk_decoder.sv]
// Huffman tree-walk decoder top level: node table, walk sequencer, output register.
// Depends on htwd_pkg and htwd_ram.
`timescale 1ns / 1ps

// Usage.
// The req channel carries two kinds of transaction, told apart by req_tuser.
// A load transaction writes one tree node into the 512-entry node table and
// leaves the block ready; a load to slot 511 is dropped. A decode transaction
// carries one code byte, walked most significant bit first through the table.
// Every leaf reached yields one rsp transaction with the leaf's symbol;
// rsp_tlast marks the last symbol produced by that code byte, and a byte that
// reaches no leaf yields nothing. The walk position carries over between bytes.
// A decode runs from acceptance to readiness for the next transaction through
// two setup reads (current node, root node), then one table read per code bit
// through the single read port of the node RAM, then a flush state that releases
// the held-back final symbol. When the receiver stalls, the walk halts on the
// next leaf that must hand a symbol to the full output register.
// csr_we writes symbol_count (clamped to 2..MAX_SYMBOLS), which sets the root
// to 2*symbol_count-2 and moves the walk there; write it only while idle.
// Synchronous reset empties the output, returns to idle and sets the root for
// MAX_SYMBOLS symbols. The node table is not cleared: load before decoding.

module huffman_tree_walk_decoder #(
   parameter int MAX_SYMBOLS = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: node_index[8:0], left_child[17:9], right_child[26:18],
   // node_is_leaf[27], node_symbol[35:28], code_byte[43:36], zero fill[47:44].
   input  logic [47:0] req_tdata,
   // tuser: op (0 = load node, 1 = decode byte).
   input  logic        req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata from bit 0: symbol[7:0].
   output logic [7:0]  rsp_tdata,
   // tlast: last_of_byte.
   output logic        rsp_tlast,
   // Configuration port for symbol_count.
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata
);

   localparam int AW = htwd_pkg::NODE_AW;
   localparam logic [AW-1:0] MAX_ROOT = AW'(2 * MAX_SYMBOLS - 2);
   localparam logic [8:0]    MAX_COUNT = 9'(MAX_SYMBOLS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_POS,
      S_ROOT,
      S_STEP,
      S_FLUSH
   } state_type;

   // Request fields.
   logic [AW-1:0] req_node_index;
   logic [AW-1:0] req_left_child;
   logic [AW-1:0] req_right_child;
   logic          req_node_is_leaf;
   logic [7:0]    req_node_symbol;
   logic [7:0]    req_code_byte;

   assign req_node_index   = req_tdata[8:0];
   assign req_left_child   = req_tdata[17:9];
   assign req_right_child  = req_tdata[26:18];
   assign req_node_is_leaf = req_tdata[27];
   assign req_node_symbol  = req_tdata[35:28];
   assign req_code_byte    = req_tdata[43:36];

   // Registers and next values.
   state_type          state_ff, state_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      root_ff, root_in;
   logic [7:0]         bits_ff, bits_in;
   logic [2:0]         cnt_ff, cnt_in;
   htwd_pkg::node_type cur_ff, cur_in;
   htwd_pkg::node_type root_node_ff, root_node_in;
   logic [AW-1:0]      child_ff, child_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [7:0]         pend_sym_ff, pend_sym_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [7:0]         rsp_sym_ff, rsp_sym_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               zero_rd_ff, zero_rd_in;

   // Node RAM.
   logic               ram_wr_en;
   htwd_pkg::node_type ram_wr_node;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [htwd_pkg::NODE_W-1:0] ram_rd_data;

   logic               req_accept;
   htwd_pkg::node_type rd_node;
   htwd_pkg::node_type next_cur;
   logic [AW-1:0]      next_pos;
   logic               out_free;
   logic               step_stall;
   logic               push;
   logic               push_last;
   logic [8:0]         count_clamped;
   logic [AW:0]        root_wide;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign ram_wr_en = req_accept && (req_tuser == htwd_pkg::OP_LOAD)
                      && (req_node_index != htwd_pkg::NULL_SLOT);
   assign ram_wr_node = '{left_child:  req_left_child,
                          right_child: req_right_child,
                          is_leaf:     req_node_is_leaf,
                          sym:         req_node_symbol};

   htwd_ram #(
      .WIDTH(htwd_pkg::NODE_W),
      .DEPTH(htwd_pkg::NODE_SLOTS)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_node_index),
      .wr_data (ram_wr_node),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Reads of the null slot see an all-zero node whatever the RAM holds.
   assign rd_node = zero_rd_ff ? '0 : htwd_pkg::node_type'(ram_rd_data);

   // A reached leaf sends the walk back to the root, whose node is cached.
   assign next_cur = rd_node.is_leaf ? root_node_ff : rd_node;
   assign next_pos = rd_node.is_leaf ? root_ff : child_ff;

   assign out_free = !rsp_vld_ff || rsp_tready;

   // A new leaf pushes the previously held symbol out; wait if the output is full.
   assign step_stall = (state_ff == S_STEP) && rd_node.is_leaf && pend_vld_ff && !out_free;

   // Root for a newly written symbol count.
   always_comb begin
      count_clamped = csr_wdata;
      if (csr_wdata < 9'd2) begin
         count_clamped = 9'd2;
      end else if (csr_wdata > MAX_COUNT) begin
         count_clamped = MAX_COUNT;
      end
      root_wide = {count_clamped, 1'b0} - 10'd2;
   end

   // Read port address: the current node, then the root, then one child per bit.
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_ff;
      case (state_ff)
         S_IDLE: begin
            ram_rd_en   = req_accept && (req_tuser == htwd_pkg::OP_DECODE);
            ram_rd_addr = pos_ff;
         end
         S_POS: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = root_ff;
         end
         S_ROOT: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = bits_ff[7] ? cur_ff.right_child : cur_ff.left_child;
         end
         S_STEP: begin
            ram_rd_en   = !step_stall && (cnt_ff != 3'(htwd_pkg::BYTE_BITS - 1));
            ram_rd_addr = bits_ff[7] ? next_cur.right_child : next_cur.left_child;
         end
         default: begin
            ram_rd_en   = 1'b0;
            ram_rd_addr = pos_ff;
         end
      endcase
   end

   // Walk sequencer and output register.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      root_in      = root_ff;
      bits_in      = bits_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      root_node_in = root_node_ff;
      child_in     = child_ff;
      pend_vld_in  = pend_vld_ff;
      pend_sym_in  = pend_sym_ff;
      zero_rd_in   = zero_rd_ff;
      push         = 1'b0;
      push_last    = 1'b0;

      if (ram_rd_en) begin
         zero_rd_in = (ram_rd_addr == htwd_pkg::NULL_SLOT);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_tuser == htwd_pkg::OP_DECODE)) begin
               bits_in  = req_code_byte;
               state_in = S_POS;
            end
         end
         S_POS: begin
            cur_in   = rd_node;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            root_node_in = rd_node;
            child_in     = ram_rd_addr;
            bits_in      = {bits_ff[6:0], 1'b0};
            cnt_in       = '0;
            state_in     = S_STEP;
         end
         S_STEP: begin
            if (!step_stall) begin
               if (rd_node.is_leaf) begin
                  push        = pend_vld_ff;
                  pend_vld_in = 1'b1;
                  pend_sym_in = rd_node.sym;
               end
               cur_in = next_cur;
               if (cnt_ff == 3'(htwd_pkg::BYTE_BITS - 1)) begin
                  pos_in   = next_pos;
                  state_in = S_FLUSH;
               end else begin
                  child_in = ram_rd_addr;
                  bits_in  = {bits_ff[6:0], 1'b0};
                  cnt_in   = cnt_ff + 3'd1;
               end
            end
         end
         S_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               push        = 1'b1;
               push_last   = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Configuration write retargets the root and restarts the walk there.
      if (csr_we) begin
         root_in = root_wide[AW-1:0];
         pos_in  = root_wide[AW-1:0];
      end

      rsp_vld_in  = rsp_vld_ff;
      rsp_sym_in  = rsp_sym_ff;
      rsp_last_in = rsp_last_ff;
      if (push) begin
         rsp_vld_in  = 1'b1;
         rsp_sym_in  = pend_sym_ff;
         rsp_last_in = push_last;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pos_ff      <= MAX_ROOT;
         root_ff     <= MAX_ROOT;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         root_ff     <= root_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      bits_ff      <= bits_in;
      cnt_ff       <= cnt_in;
      cur_ff       <= cur_in;
      root_node_ff <= root_node_in;
      child_ff     <= child_in;
      pend_sym_ff  <= pend_sym_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_last_ff  <= rsp_last_in;
      zero_rd_ff   <= zero_rd_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_sym_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/htwd_checker.sv]
// Port-level checker for the Huffman tree-walk decoder, bound to its top level.
// Depends on htwd_pkg and huffman_tree_walk_decoder_defines.svh.
`timescale 1ns / 1ps
`include "huffman_tree_walk_decoder_defines.svh"

module htwd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled response transaction holds its payload.
   `HTWD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "response changed while stalled")

   // A decode transaction leaves the block not ready right after its acceptance.
   `HTWD_ASSERT_NEXT(a_decode_busy, clock, reset, req_tvalid && req_tready && (req_tuser == htwd_pkg::OP_DECODE), !req_tready, "ready right after a decode")

   // While idle with an empty output, no response can appear by itself.
   `HTWD_ASSERT_NEXT(a_idle_quiet, clock, reset, req_tready && !rsp_tvalid, !rsp_tvalid, "response without a decode")

   // A load transaction never produces a response.
   `HTWD_ASSERT_NEXT(a_load_silent, clock, reset, req_tvalid && req_tready && (req_tuser == htwd_pkg::OP_LOAD) && !rsp_tvalid, !rsp_tvalid, "response after a load")

endmodule

bind huffman_tree_walk_decoder htwd_checker u_htwd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[test/tb.sv]
// Self-checking testbench for the Huffman tree-walk decoder.
// Loads node tables, streams code bytes and checks each decoded symbol against
// an in-bench tree walk. Depends on htwd_pkg and the huffman_tree_walk_decoder RTL.
`timescale 1ns / 1ps

module tb;

   localparam int MAX_SYMBOLS   = 256;
   localparam int ITEM_TARGET   = 380;
   // A byte that reaches no leaf gives no sign of being done, so settle for
   // longer than a decode takes to finish before a csr write.
   localparam int SETTLE_CYCLES = 16;
   // Cycles with no transaction on either channel before the run is abandoned.
   localparam int IDLE_LIMIT    = 4000;

   typedef struct {
      logic [7:0] symbol;
      logic       last_of_byte;
   } decoded_symbol_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = htwd_pkg::OP_LOAD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [8:0]  csr_wdata = '0;

   // Shadow copy of the decoder state. Loads to slot 511 are dropped and it always
   // reads as an all-zero node, so it counts as written from the start.
   htwd_pkg::node_type node_model [0:htwd_pkg::NODE_SLOTS-1];
   bit                 node_written [0:htwd_pkg::NODE_SLOTS-1];
   bit                 slot_taken [0:htwd_pkg::NODE_SLOTS-1];
   logic [8:0]         root_index = 9'd510;
   logic [8:0]         walk_position = 9'd510;
   decoded_symbol_type pending_symbols [$];

   int          items_sent = 0;
   int          burst_left = 0;
   int          mismatches = 0;
   int          idle_cycles = 0;
   int unsigned stall_mode = 0;
   int unsigned mode_cycles = 0;

   huffman_tree_walk_decoder #(
      .MAX_SYMBOLS(MAX_SYMBOLS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Root of the tree for a symbol_count value, with the same clamping to
   // 2..MAX_SYMBOLS that the decoder applies.
   function automatic logic [8:0] root_for(input logic [8:0] count);
      int clamped;
      clamped = count;
      if (clamped < 2) clamped = 2;
      if (clamped > MAX_SYMBOLS) clamped = MAX_SYMBOLS;
      return 9'(2 * clamped - 2);
   endfunction

   function automatic void record_node(input logic [8:0] slot, left, right,
                                       input logic leaf, input logic [7:0] sym);
      if (slot != htwd_pkg::NULL_SLOT) begin
         node_model[slot].left_child  = left;
         node_model[slot].right_child = right;
         node_model[slot].is_leaf     = leaf;
         node_model[slot].sym         = sym;
         node_written[slot]           = 1'b1;
      end
   endfunction

   // True when walking this byte from the current position touches only
   // nodes that have been loaded. Reading a never-written node is outside
   // the decoder's contract, so such bytes are simply not sent.
   function automatic bit walk_is_defined(input logic [7:0] code);
      logic [8:0] pos;
      logic [7:0] bits;
      pos  = walk_position;
      bits = code;
      for (int i = 0; i < htwd_pkg::BYTE_BITS; i++) begin
         if (!node_written[pos]) return 1'b0;
         pos = bits[7] ? node_model[pos].right_child : node_model[pos].left_child;
         if (!node_written[pos]) return 1'b0;
         if (node_model[pos].is_leaf) pos = root_index;
         bits = bits << 1;
      end
      return 1'b1;
   endfunction

   // Walks one code byte MSB first and queues the symbols it reaches; the
   // last one of the byte carries tlast. The position carries into the next byte.
   function automatic void walk_code_byte(input logic [7:0] code);
      logic [8:0]         pos;
      logic [7:0]         bits;
      int                 first;
      decoded_symbol_type hit;
      pos   = walk_position;
      bits  = code;
      first = pending_symbols.size();
      for (int i = 0; i < htwd_pkg::BYTE_BITS; i++) begin
         pos = bits[7] ? node_model[pos].right_child : node_model[pos].left_child;
         if (node_model[pos].is_leaf) begin
            hit.symbol       = node_model[pos].sym;
            hit.last_of_byte = 1'b0;
            pending_symbols.push_back(hit);
            pos = root_index;
         end
         bits = bits << 1;
      end
      walk_position = pos;
      if (pending_symbols.size() > first)
         pending_symbols[pending_symbols.size() - 1].last_of_byte = 1'b1;
   endfunction

   // Sends one request transaction. The sender runs in bursts of random
   // length separated by random gaps; a gap of zero joins two bursts. The
   // prediction is made as the transaction is offered, which is before any
   // of its symbols can come back.
   task automatic drive_request(input logic op, input logic [8:0] slot, left, right,
                                input logic leaf, input logic [7:0] sym, code);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'h0, code, sym, leaf, right, left, slot};
      if (op == htwd_pkg::OP_LOAD) record_node(slot, left, right, leaf, sym);
      else walk_code_byte(code);
      do @(posedge clock); while (!req_tready);
      burst_left--;
      items_sent++;
   endtask

   // The code byte field is ignored by loads and is filled at random.
   task automatic send_load(input logic [8:0] slot, left, right,
                            input logic leaf, input logic [7:0] sym);
      drive_request(htwd_pkg::OP_LOAD, slot, left, right, leaf, sym,
                    8'($urandom_range(0, 255)));
   endtask

   // The node fields are ignored by decodes and are filled at random.
   task automatic send_decode(input logic [7:0] code);
      if (walk_is_defined(code))
         drive_request(htwd_pkg::OP_DECODE, 9'($urandom_range(0, 511)),
                       9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                       1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), code);
   endtask

   task automatic release_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   // symbol_count is only written with the decoder idle: every queued symbol
   // has arrived and the last decode has had time to finish.
   task automatic write_symbol_count(input logic [8:0] value);
      release_requests();
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      root_index    = root_for(value);
      walk_position = root_index;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [8:0] claim_free_slot();
      logic [8:0] slot;
      do slot = 9'($urandom_range(0, 510)); while (slot_taken[slot]);
      slot_taken[slot] = 1'b1;
      return slot;
   endfunction

   // Builds a full binary tree with the given number of leaves on random
   // slots, merging random pairs until the last parent lands on the root.
   // Now and then a decode is tried before the tree is complete.
   task automatic load_random_tree(input int leaves);
      logic [8:0] pool [$];
      logic [8:0] a, b, slot;
      int         k;
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      slot_taken[root_index]         = 1'b1;
      slot_taken[htwd_pkg::NULL_SLOT] = 1'b1;
      repeat (leaves) begin
         slot = claim_free_slot();
         send_load(slot, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), 1'b1,
                   8'($urandom_range(0, 255)));
         pool.push_back(slot);
      end
      while (pool.size() > 1) begin
         k = $urandom_range(0, pool.size() - 1);
         a = pool[k];
         pool.delete(k);
         k = $urandom_range(0, pool.size() - 1);
         b = pool[k];
         pool.delete(k);
         slot = (pool.size() == 0) ? root_index : claim_free_slot();
         if ($urandom_range(0, 1) == 1)
            send_load(slot, a, b, 1'b0, 8'($urandom_range(0, 255)));
         else
            send_load(slot, b, a, 1'b0, 8'($urandom_range(0, 255)));
         pool.push_back(slot);
         if ($urandom_range(0, 11) == 0) send_decode(8'($urandom_range(0, 255)));
      end
   endtask

   // Reset root (510) with a small tree: a leaf on bit 0 gives eight symbols
   // from one byte, and the path 1-0 passes through slot 511, whose load is
   // dropped and which reads as a zero node that leads to slot 0.
   task automatic test_default_root_and_null_slot();
      send_load(9'd0, 9'h1FF, 9'h000, 1'b1, 8'h00);
      send_load(9'd1, 9'h000, 9'h1FF, 1'b1, 8'hFF);
      send_load(9'd509, htwd_pkg::NULL_SLOT, 9'd1, 1'b0, 8'hA5);
      send_load(htwd_pkg::NULL_SLOT, 9'd1, 9'd1, 1'b1, 8'hC3);
      send_load(9'd510, 9'd0, 9'd509, 1'b0, 8'h5A);
      send_decode(8'h00);
      send_decode(8'hFF);
      send_decode(8'h80);
      send_decode(8'hA4);
      send_decode(8'h9B);
   endtask

   // symbol_count 2 puts the root at 2. Node 3 loops on bit 0, so an all-zero
   // byte reaches no leaf and the walk stays at 3 into the next byte.
   task automatic test_walk_across_bytes();
      write_symbol_count(9'd2);
      send_load(9'd3, 9'd3, 9'd4, 1'b0, 8'h11);
      send_load(9'd4, 9'd2, 9'd3, 1'b1, 8'h77);
      send_load(9'd2, 9'd3, 9'd4, 1'b0, 8'h22);
      send_decode(8'h00);
      send_decode(8'h00);
      send_decode(8'h01);
      send_decode(8'h55);
   endtask

   // Values below 2 clamp to 2 and values above MAX_SYMBOLS clamp to it. A
   // root that is itself a leaf is walked through like any node. Each write
   // also moves the walk back to the root, away from the loop at node 3.
   task automatic test_leaf_root_and_clamping();
      send_decode(8'h00);
      write_symbol_count(9'd1);
      send_load(9'd2, 9'd4, 9'd3, 1'b1, 8'h33);
      send_decode(8'hC6);
      write_symbol_count(9'd0);
      send_decode(8'h3A);
      write_symbol_count(9'd511);
      send_decode(8'h6E);
      write_symbol_count(9'd257);
      send_decode(8'h1F);
      write_symbol_count(9'd256);
      send_decode(8'h96);
   endtask

   // Mostly well-formed trees with random shape and content followed by a
   // stream of code bytes, with stray loads mixed in as noise. Most trees are
   // small; a few are larger and the root moves over its whole range.
   task automatic test_random_trees();
      logic [8:0] count;
      int         pick;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) count = 9'($urandom_range(0, 1));
         else if (pick == 1) count = 9'($urandom_range(257, 511));
         else if (pick <= 3) count = 9'($urandom_range(9, 256));
         else count = 9'($urandom_range(2, 8));
         write_symbol_count(count);
         load_random_tree(($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                       : $urandom_range(2, 5));
         repeat ($urandom_range(4, 16)) begin
            if ($urandom_range(0, 9) == 0)
               send_load(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                         9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
            else
               send_decode(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Receiver: picks a stall pattern for a stretch of cycles. Two of the four
   // patterns never stall, one stalls at random and one accepts only when the
   // cycles left in the stretch are a multiple of four.
   always @(negedge clock) begin
      if (mode_cycles == 0) begin
         stall_mode  = $urandom_range(0, 3);
         mode_cycles = $urandom_range(16, 96);
      end
      mode_cycles--;
      case (stall_mode)
         0, 1: begin
            rsp_tready <= 1'b1;
         end
         2: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_tready <= (mode_cycles % 4 == 0);
         end
      endcase
   end

   // Every rsp transaction is matched against the oldest queued symbol.
   always @(posedge clock) begin
      decoded_symbol_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_symbols.size() == 0) begin
            $error("unexpected rsp transaction: symbol 8'h%02h, tlast %0b",
                   rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = pending_symbols.pop_front();
            if (rsp_tdata !== want.symbol) begin
               $error("symbol mismatch: expected 8'h%02h, actual 8'h%02h",
                      want.symbol, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== want.last_of_byte) begin
               $error("last_of_byte mismatch: expected %0b, actual %0b",
                      want.last_of_byte, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: a run with no transaction on either channel for too long has hung.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      foreach (node_written[i]) node_written[i] = 1'b0;
      node_model[htwd_pkg::NULL_SLOT]   = '0;
      node_written[htwd_pkg::NULL_SLOT] = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_root_and_null_slot();
      test_walk_across_bytes();
      test_leaf_root_and_clamping();
      test_random_trees();

      release_requests();
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
